>>> rtl/mmul_pkg.sv
// mmul_pkg: types, constants and helper functions for the matrix multiply engine
// no dependencies; imported by the core, mmul_seq, mmul_cell and the testbench
package mmul_pkg;

   localparam int MAX_DIM   = 8;
   localparam int FRAC_BITS = 16;

   localparam int VAL_W   = 32;
   localparam int IDX_W   = $clog2(MAX_DIM);
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int PROD_W  = 2 * VAL_W;
   localparam int SUM_W   = PROD_W - FRAC_BITS + $clog2(MAX_DIM) + 1;
   localparam int REG_W   = 4;
   localparam int CSR_W   = 2;
   localparam int Q_DEPTH = 2 * MAX_DIM;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   typedef enum logic [1:0] {
      KIND_LEFT  = 2'd0,
      KIND_RIGHT = 2'd1,
      KIND_PROD  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_LEFT_ROWS     = 2'd0,
      CSR_INNER_SIZE    = 2'd1,
      CSR_RIGHT_COLUMNS = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_type;

   // one product element walking the cell chain
   typedef struct packed {
      logic                    valid;
      logic                    last;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic [DIM_W-1:0]        nterm;
      logic signed [SUM_W-1:0] sum;
   } token_type;

   // one read pair issued by the sequencer
   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [DIM_W-1:0]  nterm;
      logic [ADDR_W-1:0] left_addr;
      logic [ADDR_W-1:0] right_addr;
   } issue_type;

   function automatic logic [DIM_W-1:0] dim_of(input logic [REG_W-1:0] value);
      logic [DIM_W-1:0] d;
      if (value == '0) begin
         d = DIM_W'(1);
      end else if (32'(value) > MAX_DIM) begin
         d = DIM_W'(MAX_DIM);
      end else begin
         d = DIM_W'(value);
      end
      return d;
   endfunction

   function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] row,
                                                 input logic [IDX_W-1:0] col);
      return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col));
   endfunction

endpackage

>>> rtl/matrix_multiply_engine_core.sv
// matrix_multiply_engine_core: top level of the Q16.16 matrix multiply engine
// depends on mmul_pkg, mmul_ram, mmul_seq and mmul_cell
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | kind, row_index, column_index, element_value
//   rsp     | out       | rsp_valid / rsp_stall | out_row, out_column, product_value, last_element
//   csr     | in        | csr_write_enable      | csr_index, csr_write_data
//
// element writes go back to back while no run is reading the stores
// a compute run reads one entry of each store per cycle (single read port per store),
// but a new element waits for fifo credit; each element reaches the fifo through the read,
// multiply and cell chain stages
// req_stall is high while a run is still reading the stores; results queue in a
// 2*MAX_DIM deep fifo and a new product element starts only when it has a slot
// reset is synchronous and clears control state only; stores hold garbage until written
module matrix_multiply_engine_core import mmul_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_kind,
   input  logic [2:0]              req_row_index,
   input  logic [2:0]              req_column_index,
   input  logic signed [VAL_W-1:0] req_element_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_out_row,
   output logic [2:0]              rsp_out_column,
   output logic signed [VAL_W-1:0] rsp_product_value,
   output logic                    rsp_last_element,
   input  logic                    csr_write_enable,
   input  logic [CSR_W-1:0]        csr_index,
   input  logic [REG_W-1:0]        csr_write_data
);

   typedef struct packed {
      logic             last;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [VAL_W-1:0] value;
   } result_type;

   logic [REG_W-1:0] left_rows_ff, inner_size_ff, right_columns_ff;

   logic      req_xfer, rsp_xfer, wr_ok, busy, credit_ok, start;
   logic      wr_left, wr_right;
   issue_type issue, tag_a_ff, tag_b_ff;
   logic [VAL_W-1:0] left_rd, right_rd;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  term;
   token_type chain [MAX_DIM+1];

   logic [Q_AW:0]     credit_ff, credit_in;
   logic [Q_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_AW:0]     fill_ff;
   result_type        q_ff [Q_DEPTH];
   result_type        head, push_data;
   logic              push;
   logic [SUM_W-32:0] sum_hi;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         left_rows_ff     <= REG_W'(4);
         inner_size_ff    <= REG_W'(4);
         right_columns_ff <= REG_W'(4);
      end else if (csr_write_enable) begin
         unique case (csr_type'(csr_index))
            CSR_LEFT_ROWS:     left_rows_ff     <= csr_write_data;
            CSR_INNER_SIZE:    inner_size_ff    <= csr_write_data;
            CSR_RIGHT_COLUMNS: right_columns_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input decode
   assign req_stall = busy;
   assign req_xfer  = req_valid && !req_stall;
   assign wr_ok     = (32'(req_row_index) < MAX_DIM) && (32'(req_column_index) < MAX_DIM);
   assign wr_left   = req_xfer && wr_ok && (kind_type'(req_kind) == KIND_LEFT);
   assign wr_right  = req_xfer && wr_ok && (kind_type'(req_kind) == KIND_RIGHT);
   assign start     = req_xfer && (kind_type'(req_kind) == KIND_PROD);

   mmul_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .left_rows     (left_rows_ff),
      .inner_size    (inner_size_ff),
      .right_columns (right_columns_ff),
      .credit_ok     (credit_ok),
      .busy          (busy),
      .issue         (issue)
   );

   mmul_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_left_ram (
      .clock   (clock),
      .wr_en   (wr_left),
      .wr_addr (addr_of(IDX_W'(req_row_index), IDX_W'(req_column_index))),
      .wr_data (req_element_value),
      .rd_addr (issue.left_addr),
      .rd_data (left_rd)
   );

   mmul_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_right_ram (
      .clock   (clock),
      .wr_en   (wr_right),
      .wr_addr (addr_of(IDX_W'(req_row_index), IDX_W'(req_column_index))),
      .wr_data (req_element_value),
      .rd_addr (issue.right_addr),
      .rd_data (right_rd)
   );

   // read stage then multiply stage, tags follow the data
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff.valid <= 1'b0;
         tag_b_ff.valid <= 1'b0;
      end else begin
         tag_a_ff.valid <= issue.valid;
         tag_b_ff.valid <= tag_a_ff.valid;
      end
      tag_a_ff.first      <= issue.first;
      tag_a_ff.last       <= issue.last;
      tag_a_ff.row        <= issue.row;
      tag_a_ff.col        <= issue.col;
      tag_a_ff.nterm      <= issue.nterm;
      tag_a_ff.left_addr  <= issue.left_addr;
      tag_a_ff.right_addr <= issue.right_addr;
      tag_b_ff.first      <= tag_a_ff.first;
      tag_b_ff.last       <= tag_a_ff.last;
      tag_b_ff.row        <= tag_a_ff.row;
      tag_b_ff.col        <= tag_a_ff.col;
      tag_b_ff.nterm      <= tag_a_ff.nterm;
      tag_b_ff.left_addr  <= tag_a_ff.left_addr;
      tag_b_ff.right_addr <= tag_a_ff.right_addr;
      prod_ff             <= $signed(left_rd) * $signed(right_rd);
   end

   // arithmetic shift rounds toward minus infinity
   assign term = SUM_W'(prod_ff >>> FRAC_BITS);

   // a token enters the chain with the first inner term of its element
   always_comb begin
      chain[0].valid = tag_b_ff.valid && tag_b_ff.first;
      chain[0].last  = tag_b_ff.last;
      chain[0].row   = tag_b_ff.row;
      chain[0].col   = tag_b_ff.col;
      chain[0].nterm = tag_b_ff.nterm;
      chain[0].sum   = '0;
   end

   for (genvar i = 0; i < MAX_DIM; i++) begin : g_cell
      mmul_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .term       (term),
         .tok_in     (chain[i]),
         .tok_out    (chain[i+1])
      );
   end

   // saturate to the signed 32-bit range
   always_comb begin
      sum_hi          = chain[MAX_DIM].sum[SUM_W-1:31];
      push            = chain[MAX_DIM].valid;
      push_data.last  = chain[MAX_DIM].last;
      push_data.row   = chain[MAX_DIM].row;
      push_data.col   = chain[MAX_DIM].col;
      if ((&sum_hi) || !(|sum_hi)) begin
         push_data.value = chain[MAX_DIM].sum[VAL_W-1:0];
      end else if (chain[MAX_DIM].sum[SUM_W-1]) begin
         push_data.value = 32'h8000_0000;
      end else begin
         push_data.value = 32'h7fff_ffff;
      end
   end

   // result fifo and credits for elements in flight
   assign head      = q_ff[rd_ptr_ff];
   assign rsp_valid = fill_ff != '0;
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign credit_ok = credit_ff < (Q_AW+1)'(Q_DEPTH);

   always_comb begin
      credit_in = credit_ff;
      if (issue.valid && issue.first && !rsp_xfer) begin
         credit_in = credit_ff + 1'b1;
      end else if (rsp_xfer && !(issue.valid && issue.first)) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         credit_ff <= credit_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rsp_xfer) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !rsp_xfer) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (rsp_xfer && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_out_row       = 3'(head.row);
   assign rsp_out_column    = 3'(head.col);
   assign rsp_product_value = head.value;
   assign rsp_last_element  = head.last;

   assert property (@(posedge clock) disable iff (reset)
      credit_ff <= (Q_AW+1)'(Q_DEPTH))
      else $error("credit count above fifo depth");

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= credit_ff)
      else $error("fifo holds more results than issued elements");

   assert property (@(posedge clock) disable iff (reset)
      push |-> fill_ff < (Q_AW+1)'(Q_DEPTH) || rsp_xfer)
      else $error("result pushed into a full fifo");

   assert property (@(posedge clock) disable iff (reset)
      (issue.valid && !issue.first) |=> $past(busy))
      else $error("inner term issued outside a run");

endmodule

>>> rtl/mmul_ram.sv
// mmul_ram: generic single write port, single read port ram with registered read
// no dependencies
module mmul_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/mmul_seq.sv
// mmul_seq: walks column, row and inner index of a compute run, one read pair a cycle
// except while a new element waits for fifo credit; depends on mmul_pkg
module mmul_seq import mmul_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [REG_W-1:0] left_rows,
   input  logic [REG_W-1:0] inner_size,
   input  logic [REG_W-1:0] right_columns,
   input  logic             credit_ok,
   output logic             busy,
   output issue_type        issue
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] k_ff, k_in, r_ff, r_in, c_ff, c_in;
   logic [DIM_W-1:0] nr_ff, nr_in, nk_ff, nk_in, nc_ff, nc_in;
   logic             last_k, last_r, last_c, go;

   always_comb begin
      last_k = DIM_W'(k_ff) == nk_ff - 1'b1;
      last_r = DIM_W'(r_ff) == nr_ff - 1'b1;
      last_c = DIM_W'(c_ff) == nc_ff - 1'b1;
      // a new element starts only with room for its result
      go     = (state_ff == ST_RUN) && ((k_ff != '0) || credit_ok);

      state_in = state_ff;
      k_in = k_ff;
      r_in = r_ff;
      c_in = c_ff;
      nr_in = nr_ff;
      nk_in = nk_ff;
      nc_in = nc_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               nr_in    = dim_of(left_rows);
               nk_in    = dim_of(inner_size);
               nc_in    = dim_of(right_columns);
               k_in     = '0;
               r_in     = '0;
               c_in     = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (go) begin
               if (!last_k) begin
                  k_in = k_ff + 1'b1;
               end else begin
                  k_in = '0;
                  if (!last_r) begin
                     r_in = r_ff + 1'b1;
                  end else begin
                     r_in = '0;
                     if (last_c) begin
                        state_in = ST_IDLE;
                     end else begin
                        c_in = c_ff + 1'b1;
                     end
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      issue.valid      = go;
      issue.first      = k_ff == '0;
      issue.last       = last_r && last_c;
      issue.row        = r_ff;
      issue.col        = c_ff;
      issue.nterm      = nk_ff;
      issue.left_addr  = addr_of(r_ff, k_ff);
      issue.right_addr = addr_of(k_ff, c_ff);
   end

   assign busy = state_ff == ST_RUN;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      k_ff  <= k_in;
      r_ff  <= r_in;
      c_ff  <= c_in;
      nr_ff <= nr_in;
      nk_ff <= nk_in;
      nc_ff <= nc_in;
   end

endmodule

>>> rtl/mmul_cell.sv
// mmul_cell: one link of the accumulate chain, adds the inner term of its own index
// depends on mmul_pkg
module mmul_cell import mmul_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [IDX_W-1:0]        cell_index,
   input  logic signed [SUM_W-1:0] term,
   input  token_type               tok_in,
   output token_type               tok_out
);

   token_type tok_ff, tok_in_nx;

   always_comb begin
      tok_in_nx = tok_in;
      // the broadcast term belongs to this token only while its index is in range
      if (DIM_W'(cell_index) < tok_in.nterm) begin
         tok_in_nx.sum = tok_in.sum + term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_nx.valid;
      end
      tok_ff.last  <= tok_in_nx.last;
      tok_ff.row   <= tok_in_nx.row;
      tok_ff.col   <= tok_in_nx.col;
      tok_ff.nterm <= tok_in_nx.nterm;
      tok_ff.sum   <= tok_in_nx.sum;
   end

   assign tok_out = tok_ff;

endmodule

>>> tb/sv/testbench.sv
// testbench: self-checking bench for matrix_multiply_engine_core
// depends on mmul_pkg and the engine RTL; predicts every product element in SV
module testbench;
   import mmul_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int DRAIN_CYCLES   = 3 * MAX_DIM * MAX_DIM + 4 * MAX_DIM;

   typedef struct {
      logic [2:0]  row;
      logic [2:0]  col;
      logic [31:0] value;
      logic        last;
   } element_type;

   typedef struct {
      kind_type    kind;
      logic [2:0]  row;
      logic [2:0]  col;
      logic [31:0] value;
      bit          typed;
      logic [31:0] typed_value;
   } stim_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic [2:0]  req_row_index;
   logic [2:0]  req_column_index;
   logic signed [VAL_W-1:0] req_element_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_out_row;
   logic [2:0]  rsp_out_column;
   logic signed [VAL_W-1:0] rsp_product_value;
   logic        rsp_last_element;
   logic        csr_write_enable;
   logic [CSR_W-1:0] csr_index;
   logic [REG_W-1:0] csr_write_data;

   // predictor state
   logic [31:0] left_mem [DEPTH];
   logic [31:0] right_mem [DEPTH];
   bit          left_known [DEPTH];
   bit          right_known [DEPTH];
   logic [3:0]  rows_reg, inner_reg, cols_reg;

   element_type pending_elements[$];
   int  error_count;
   int  items_sent;
   int  computes_sent;
   int  elements_checked;
   int  idle_cycles;
   int  burst_left;
   int  stall_phase;

   matrix_multiply_engine_core u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int eff_dim(logic [3:0] value);
      if (value == 0) return 1;
      if (value > MAX_DIM) return MAX_DIM;
      return int'(value);
   endfunction

   // true when a product run would read only entries that were written
   function automatic bit product_ready();
      int nr, nk, nc;
      nr = eff_dim(rows_reg);
      nk = eff_dim(inner_reg);
      nc = eff_dim(cols_reg);
      for (int k = 0; k < nk; k++) begin
         for (int r = 0; r < nr; r++)
            if (!left_known[r * MAX_DIM + k]) return 0;
         for (int c = 0; c < nc; c++)
            if (!right_known[k * MAX_DIM + c]) return 0;
      end
      return 1;
   endfunction

   // queue the product elements, column-major, sums saturated once at the end
   task automatic predict_product();
      int nr, nk, nc;
      longint acc, term;
      element_type e;
      nr = eff_dim(rows_reg);
      nk = eff_dim(inner_reg);
      nc = eff_dim(cols_reg);
      for (int c = 0; c < nc; c++) begin
         for (int r = 0; r < nr; r++) begin
            acc = 0;
            for (int k = 0; k < nk; k++) begin
               term = longint'($signed(left_mem[r * MAX_DIM + k]))
                    * longint'($signed(right_mem[k * MAX_DIM + c]));
               acc += term >>> FRAC_BITS;   // floor
            end
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            e.row = 3'(r);
            e.col = 3'(c);
            e.value = acc[31:0];
            e.last = (c == nc - 1) && (r == nr - 1);
            pending_elements.push_back(e);
         end
      end
   endtask

   task automatic apply_item(stim_type s);
      int at;
      at = int'(s.row) * MAX_DIM + int'(s.col);
      case (s.kind)
         KIND_LEFT: begin
            left_mem[at] = s.value;
            left_known[at] = 1;
         end
         KIND_RIGHT: begin
            right_mem[at] = s.value;
            right_known[at] = 1;
         end
         KIND_PROD: begin
            predict_product();
            computes_sent++;
            if (s.typed) pending_elements[$].value = s.typed_value;
         end
         default: ;
      endcase
   endtask

   // one transfer on the request side, with bursts and random gaps
   task automatic send_item(stim_type s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_kind          <= s.kind;
      req_row_index     <= s.row;
      req_column_index  <= s.col;
      req_element_value <= s.value;
      do @(posedge clock); while (req_stall);
      apply_item(s);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_elements.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_type idx, logic [3:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_LEFT_ROWS:     rows_reg = data;
         CSR_INNER_SIZE:    inner_reg = data;
         CSR_RIGHT_COLUMNS: cols_reg = data;
         default: ;
      endcase
   endtask

   task automatic set_dims(logic [3:0] nr, logic [3:0] nk, logic [3:0] nc);
      wait_idle();
      write_csr(CSR_LEFT_ROWS, nr);
      write_csr(CSR_INNER_SIZE, nk);
      write_csr(CSR_RIGHT_COLUMNS, nc);
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 32'h0003ffff);            // small positive
         3: return 32'(-int'($urandom_range(0, 32'h0003ffff)));
         default: return $urandom;
      endcase
   endfunction

   // results side: stall in changing patterns, check each transfer
   always @(posedge clock) begin
      element_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= (stall_phase + 1) % 600;
         if (stall_phase < 200) rsp_stall <= 1'b0;
         else if (stall_phase < 400) rsp_stall <= ($urandom_range(0, 1) == 1);
         else rsp_stall <= ($urandom_range(0, 9) < 8);
         if (rsp_valid && !rsp_stall) begin
            if (pending_elements.size() == 0) begin
               $display("%0t: product element with none expected: row %0d col %0d value %h",
                        $realtime, rsp_out_row, rsp_out_column, rsp_product_value);
               error_count++;
            end else begin
               e = pending_elements.pop_front();
               elements_checked++;
               if (rsp_out_row !== e.row || rsp_out_column !== e.col ||
                   rsp_product_value !== e.value || rsp_last_element !== e.last) begin
                  $display("%0t: expected row %0d col %0d value %h last %b, got %0d %0d %h %b",
                           $realtime, e.row, e.col, e.value, e.last, rsp_out_row,
                           rsp_out_column, rsp_product_value, rsp_last_element);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d product elements outstanding",
                  $realtime, pending_elements.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   stim_type directed [$];

   function automatic stim_type mk(kind_type k, logic [2:0] r, logic [2:0] c,
                                   logic [31:0] v, bit t = 0, logic [31:0] tv = '0);
      stim_type s;
      s.kind = k; s.row = r; s.col = c; s.value = v; s.typed = t; s.typed_value = tv;
      return s;
   endfunction

   initial begin
      stim_type s;
      int pick;
      logic [3:0] nr, nk, nc;
      error_count = 0;
      items_sent = 0;
      computes_sent = 0;
      elements_checked = 0;
      idle_cycles = 0;
      burst_left = 0;
      rows_reg = 4; inner_reg = 4; cols_reg = 4;
      foreach (left_known[i]) begin
         left_known[i] = 0;
         right_known[i] = 0;
      end
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_NONE;
      req_row_index = '0;
      req_column_index = '0;
      req_element_value = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_UNUSED;
      csr_write_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-element products, results read straight off the arithmetic
      set_dims(1, 1, 1);
      directed = '{
         mk(KIND_NONE,  5, 5, 32'h12345678),
         mk(KIND_LEFT,  0, 0, 32'h00010000),
         mk(KIND_RIGHT, 0, 0, 32'h00020000),
         mk(KIND_PROD,  7, 7, 32'hdeadbeef, 1, 32'h00020000),
         mk(KIND_LEFT,  0, 0, 32'h7fffffff),
         mk(KIND_RIGHT, 0, 0, 32'h7fffffff),
         mk(KIND_PROD,  0, 0, 32'h0,        1, 32'h7fffffff),
         mk(KIND_LEFT,  0, 0, 32'h80000000),
         mk(KIND_PROD,  0, 0, 32'h0,        1, 32'h80000000),
         mk(KIND_RIGHT, 0, 0, 32'h80000000),
         mk(KIND_PROD,  0, 0, 32'h0,        1, 32'h7fffffff),
         mk(KIND_LEFT,  0, 0, 32'hffffffff),
         mk(KIND_RIGHT, 0, 0, 32'h00000001),
         mk(KIND_PROD,  3, 4, 32'h0,        1, 32'hffffffff),   // floor of tiny negative
         mk(KIND_LEFT,  7, 7, 32'h55555555),                    // outside dims, still stored
         mk(KIND_RIGHT, 7, 7, 32'haaaaaaaa),
         mk(KIND_NONE,  7, 7, 32'hffffffff),
         mk(KIND_LEFT,  0, 0, 32'h0),
         mk(KIND_PROD,  0, 0, 32'h0,        1, 32'h0),
         mk(KIND_LEFT,  0, 0, 32'hfffe0000),
         mk(KIND_RIGHT, 0, 0, 32'h00018000),
         mk(KIND_PROD,  0, 0, 32'h0,        1, 32'hfffd0000)
      };
      foreach (directed[i]) send_item(directed[i]);

      // fill both stores completely, entries in order, random values
      for (int i = 0; i < 2 * DEPTH; i++) begin
         s = mk(i < DEPTH ? KIND_LEFT : KIND_RIGHT, 3'((i % DEPTH) / MAX_DIM),
                3'(i % MAX_DIM), random_value());
         send_item(s);
      end

      // random phases over several shapes, the extremes among them
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: begin nr = 8;  nk = 8;  nc = 8;  end
            1: begin nr = 0;  nk = 0;  nc = 0;  end
            2: begin nr = 15; nk = 15; nc = 15; end
            3: begin nr = 1;  nk = 8;  nc = 1;  end
            default: begin
               nr = 4'($urandom_range(0, 15));
               nk = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(1, 4));
               nc = 4'($urandom_range(0, 15));
            end
         endcase
         set_dims(nr, nk, nc);
         write_csr(CSR_UNUSED, 4'($urandom_range(0, 15)));   // unused index, no effect
         for (int n = 0; n < 33; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
               s = mk(KIND_NONE, 3'($urandom), 3'($urandom), $urandom);
            else if (pick < 30 && product_ready())
               s = mk(KIND_PROD, 3'($urandom), 3'($urandom), $urandom);
            else
               s = mk(pick[0] ? KIND_LEFT : KIND_RIGHT, 3'($urandom), 3'($urandom),
                      random_value());
            send_item(s);
         end
      end

      req_valid <= 1'b0;
      while (pending_elements.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests including %0d products, %0d elements checked",
               items_sent, computes_sent, elements_checked);
      $display("shapes from 1x1x1 to 8x8x8, saturation, floor rounding, unused kind and index");
      if (error_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> filelist.f
rtl/mmul_pkg.sv
rtl/mmul_ram.sv
rtl/mmul_seq.sv
rtl/mmul_cell.sv
rtl/matrix_multiply_engine_core.sv
tb/sv/testbench.sv
